/* hdl/mi3_pkg.sv */
// Shared constants for the 3x3 matrix inverse.
// No dependencies.
package mi3_pkg;
  localparam int MAT_N = 3;
  localparam int ENT_N = MAT_N * MAT_N;
endpackage

/* hdl/mi3_if.sv */
// Valid/ready channel interfaces: matrix word in, inverse word out.
// No dependencies.
interface mi3_in_if #(parameter int DATA_WIDTH = 32) ();
  logic valid;
  logic ready;
  logic signed [DATA_WIDTH-1:0] a00, a01, a02, a10, a11, a12, a20, a21, a22;
  modport source (output valid, a00, a01, a02, a10, a11, a12, a20, a21, a22,
                  input ready);
  modport sink (input valid, a00, a01, a02, a10, a11, a12, a20, a21, a22,
                output ready);
endinterface

interface mi3_out_if #(parameter int DATA_WIDTH = 32) ();
  logic valid;
  logic ready;
  logic signed [DATA_WIDTH-1:0] r00, r01, r02, r10, r11, r12, r20, r21, r22;
  logic singular;
  modport source (output valid, r00, r01, r02, r10, r11, r12, r20, r21, r22,
                  singular, input ready);
  modport sink (input valid, r00, r01, r02, r10, r11, r12, r20, r21, r22,
                singular, output ready);
endinterface

/* hdl/matrix_inverse_3x3.sv */
// 3x3 matrix inverse by adjugate, fixed point, fully pipelined.
// Depends on mi3_pkg and mi3_if.
//
//  channel   dir  signals
//  in_mat    in   valid ready a00..a22
//  out_inv   out  valid ready r00..r22 singular
//
// One word per cycle while out_inv is not stalled. The pipe holds the product,
// cofactor, determinant and setup stages, then DATA_WIDTH+2 restoring divide stages
// (an overflow check, then one quotient bit per stage), and the output register.
// Synchronous active-low reset clears the valid bits only.
// The whole pipe advances when the output register is empty or taken.
module matrix_inverse_3x3 #(
  parameter int DATA_WIDTH = 32,
  parameter int FRAC_BITS  = 16
) (
  input  logic clk,
  input  logic rst_n,
  mi3_in_if.sink    in_mat,
  mi3_out_if.source out_inv
);
  import mi3_pkg::*;

  localparam int W   = DATA_WIDTH;
  localparam int PW  = 2 * W;
  localparam int CW  = 2 * W + 1;
  localparam int DTW = 3 * W + 3;
  localparam int DVW = DTW + 1;
  localparam int QW  = W + 1;
  localparam int NA  = CW + 2 * FRAC_BITS + 1;
  localparam int NW  = ((NA > DTW) ? NA : DTW) + 1;
  localparam int RW  = ((NW > DVW + QW) ? NW : DVW + QW) + 1;

  logic adv;
  logic signed [W-1:0] a_in [ENT_N];

  assign a_in[0] = in_mat.a00;
  assign a_in[1] = in_mat.a01;
  assign a_in[2] = in_mat.a02;
  assign a_in[3] = in_mat.a10;
  assign a_in[4] = in_mat.a11;
  assign a_in[5] = in_mat.a12;
  assign a_in[6] = in_mat.a20;
  assign a_in[7] = in_mat.a21;
  assign a_in[8] = in_mat.a22;

  assign adv          = !out_inv.valid || out_inv.ready;
  assign in_mat.ready = adv;

  // stage valids: a, b, c, d, e, f
  logic va_r, vb_r, vc_r, vd_r, ve_r, vf_r;
  logic vdiv_r [QW+1];
  logic vo_r;

  logic signed [W-1:0]  a_r  [ENT_N];
  logic signed [PW-1:0] p0_r [ENT_N];
  logic signed [PW-1:0] p1_r [ENT_N];
  logic signed [CW-1:0] cr_r [ENT_N];
  logic signed [CW-1:0] crd_r [ENT_N];
  logic signed [CW-1:0] cre_r [ENT_N];
  logic signed [W-1:0]  rb_r [MAT_N];
  logic signed [W-1:0]  rc_r [MAT_N];
  logic signed [2*W:0]  plo_r [MAT_N];
  logic signed [2*W:0]  phi_r [MAT_N];
  logic signed [DTW-1:0] det_r;

  logic [RW-1:0]  remf_r [ENT_N];
  logic           negf_r [ENT_N];
  logic [DVW-1:0] df_r;
  logic           sgf_r;

  logic [RW-1:0]  rem_r [QW+1][ENT_N];
  logic [QW-1:0]  q_r   [QW+1][ENT_N];
  logic           ov_r  [QW+1][ENT_N];
  logic           ng_r  [QW+1][ENT_N];
  logic [DVW-1:0] d_r   [QW+1];
  logic           sg_r  [QW+1];

  logic signed [W-1:0] res_r [ENT_N];
  logic                sing_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
      vc_r <= 1'b0;
      vd_r <= 1'b0;
      ve_r <= 1'b0;
      vf_r <= 1'b0;
      vo_r <= 1'b0;
    end else if (adv) begin
      va_r <= in_mat.valid;
      vb_r <= va_r;
      vc_r <= vb_r;
      vd_r <= vc_r;
      ve_r <= vd_r;
      vf_r <= ve_r;
      vo_r <= vdiv_r[QW];
    end
  end

  genvar e, s, j;
  generate
    for (e = 0; e < ENT_N; e++) begin : g_ent
      // inverse entry (k, i): cross of columns l, m over rows p, q
      localparam int K  = e / MAT_N;
      localparam int I  = e % MAT_N;
      localparam int L  = (K + 1) % MAT_N;
      localparam int M  = (K + 2) % MAT_N;
      localparam int P  = (I + 1) % MAT_N;
      localparam int Q  = (I + 2) % MAT_N;
      logic [CW-1:0] cmag;
      logic [DTW-1:0] dmag;

      always_comb begin
        cmag = cre_r[e][CW-1] ? CW'(-cre_r[e]) : CW'(cre_r[e]);
        dmag = det_r[DTW-1] ? DTW'(-det_r) : DTW'(det_r);
      end

      always_ff @(posedge clk) begin
        if (adv) begin
          a_r[e]    <= a_in[e];
          p0_r[e]   <= a_r[P*MAT_N+L] * a_r[Q*MAT_N+M];
          p1_r[e]   <= a_r[Q*MAT_N+L] * a_r[P*MAT_N+M];
          cr_r[e]   <= CW'(p0_r[e]) - CW'(p1_r[e]);
          crd_r[e]  <= cr_r[e];
          cre_r[e]  <= crd_r[e];
          remf_r[e] <= (RW'(cmag) << (2 * FRAC_BITS + 1)) + RW'(dmag);
          negf_r[e] <= cre_r[e][CW-1] ^ det_r[DTW-1];
        end
      end
    end

    for (j = 0; j < MAT_N; j++) begin : g_det
      always_ff @(posedge clk) begin
        if (adv) begin
          rb_r[j]  <= a_r[j];
          rc_r[j]  <= rb_r[j];
          plo_r[j] <= rc_r[j] * $signed({1'b0, cr_r[j*MAT_N][W-1:0]});
          phi_r[j] <= rc_r[j] * $signed(cr_r[j*MAT_N][CW-1:W]);
        end
      end
    end

    for (s = 0; s <= QW; s++) begin : g_div
      always_ff @(posedge clk) begin
        if (!rst_n) begin
          vdiv_r[s] <= 1'b0;
        end else if (adv) begin
          vdiv_r[s] <= (s == 0) ? vf_r : vdiv_r[(s == 0) ? 0 : s-1];
        end
      end
      if (s == 0) begin : g_first
        always_ff @(posedge clk) begin
          if (adv) begin
            d_r[0]  <= df_r;
            sg_r[0] <= sgf_r;
          end
        end
        for (e = 0; e < ENT_N; e++) begin : g_e
          always_ff @(posedge clk) begin
            if (adv) begin
              rem_r[0][e] <= remf_r[e];
              q_r[0][e]   <= '0;
              ov_r[0][e]  <= remf_r[e] >= (RW'(df_r) << QW);
              ng_r[0][e]  <= negf_r[e];
            end
          end
        end
      end else begin : g_bit
        localparam int SH = QW - s;
        always_ff @(posedge clk) begin
          if (adv) begin
            d_r[s]  <= d_r[s-1];
            sg_r[s] <= sg_r[s-1];
          end
        end
        for (e = 0; e < ENT_N; e++) begin : g_e
          logic [RW-1:0] dsh;
          logic          ge;
          always_comb begin
            dsh = RW'(d_r[s-1]) << SH;
            ge  = rem_r[s-1][e] >= dsh;
          end
          always_ff @(posedge clk) begin
            if (adv) begin
              rem_r[s][e] <= ge ? rem_r[s-1][e] - dsh : rem_r[s-1][e];
              q_r[s][e]   <= {q_r[s-1][e][QW-2:0], ge};
              ov_r[s][e]  <= ov_r[s-1][e];
              ng_r[s][e]  <= ng_r[s-1][e];
            end
          end
        end
      end
    end

    for (e = 0; e < ENT_N; e++) begin : g_out
      logic [QW-1:0]       qv;
      logic signed [W-1:0] sat;
      always_comb begin
        qv = q_r[QW][e];
        if (sg_r[QW]) begin
          sat = '0;
        end else if (!ng_r[QW][e]) begin
          sat = (ov_r[QW][e] || qv > {2'b00, {(W-1){1'b1}}})
              ? {1'b0, {(W-1){1'b1}}} : qv[W-1:0];
        end else begin
          sat = (ov_r[QW][e] || qv > {2'b01, {(W-1){1'b0}}})
              ? {1'b1, {(W-1){1'b0}}} : -qv[W-1:0];
        end
      end
      always_ff @(posedge clk) begin
        if (adv) begin
          res_r[e] <= sat;
        end
      end
    end
  endgenerate

  logic signed [DTW-1:0] det_nxt;
  logic [DTW-1:0]        dmag_f;

  always_comb begin
    det_nxt = '0;
    for (int k = 0; k < MAT_N; k++) begin
      det_nxt = det_nxt + (DTW'(phi_r[k]) <<< W) + DTW'(plo_r[k]);
    end
    dmag_f = det_r[DTW-1] ? DTW'(-det_r) : DTW'(det_r);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      det_r  <= det_nxt;
      df_r   <= {dmag_f, 1'b0};
      sgf_r  <= (det_r == '0);
      sing_r <= sg_r[QW];
    end
  end

  assign out_inv.valid    = vo_r;
  assign out_inv.singular = sing_r;
  assign out_inv.r00      = res_r[0];
  assign out_inv.r01      = res_r[1];
  assign out_inv.r02      = res_r[2];
  assign out_inv.r10      = res_r[3];
  assign out_inv.r11      = res_r[4];
  assign out_inv.r12      = res_r[5];
  assign out_inv.r20      = res_r[6];
  assign out_inv.r21      = res_r[7];
  assign out_inv.r22      = res_r[8];

`ifndef ASSERT_OFF
  a_sing_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (vo_r && sing_r) |-> (res_r[0] == '0 && res_r[4] == '0 && res_r[8] == '0))
    else $error("singular word with nonzero inverse");

  a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    vdiv_r[0] |-> (sg_r[0] || d_r[0] != '0))
    else $error("zero divisor on nonsingular word");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> (!vo_r && !va_r))
    else $error("valid after reset");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> ($stable(vf_r) && $stable(vdiv_r[0])))
    else $error("pipe moved during stall");
`endif

endmodule
